@@ rtl/labeled_mixed_radix_offset_assert.svh @@
// ---------------------------------------------------------------------------
// labeled_mixed_radix_offset assertion macros
// clocked, reset-qualified property shorthands for the checker
// ---------------------------------------------------------------------------
`ifndef LABELED_MIXED_RADIX_OFFSET_ASSERT_SVH
`define LABELED_MIXED_RADIX_OFFSET_ASSERT_SVH

// same-cycle implication
`define LMRO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LMRO_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lmro_pkg.sv @@
// ---------------------------------------------------------------------------
// lmro_pkg
// shared types and codes of the labeled mixed-radix offset block
// ---------------------------------------------------------------------------
`default_nettype none

package lmro_pkg;

  // input item kinds
  localparam logic [1:0] OP_HEADER = 2'd0;
  localparam logic [1:0] OP_VALUE  = 2'd1;
  localparam logic [1:0] OP_PAIR   = 2'd2;
  localparam logic [1:0] OP_REV    = 2'd3;

  // result status codes
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_NO_LABEL  = 3'd1;
  localparam logic [2:0] STAT_NO_VALUE  = 3'd2;
  localparam logic [2:0] STAT_TOO_LARGE = 3'd3;
  localparam logic [2:0] STAT_ZERO_OVF  = 3'd4;

  // result kinds
  localparam logic KIND_FWD = 1'b0;
  localparam logic KIND_REV = 1'b1;

  // register word index
  localparam logic REG_DIMS = 1'b0;

  localparam logic [30:0] OFFSET_MAX = 31'h7FFF_FFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_F_DIM,
    ST_F_PAIR,
    ST_F_VADDR,
    ST_F_VCMP,
    ST_F_FIN,
    ST_R_NONE,
    ST_R_DIM,
    ST_R_DIVW,
    ST_R_EMIT
  } state_e;

endpackage

`default_nettype wire

@@ rtl/lmro_div.sv @@
// ---------------------------------------------------------------------------
// lmro_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module lmro_div #(
  parameter int unsigned DIVW = 7
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [30:0]     dividend_i,
  input  wire logic [DIVW-1:0] divisor_i,
  output logic                 done_o,
  output logic [30:0]          quot_o,
  output logic [DIVW-1:0]      rem_o
);

  logic            run_q, run_d;
  logic            done_q, done_d;
  logic [4:0]      cnt_q, cnt_d;
  logic [30:0]     quot_q, quot_d;
  logic [DIVW-1:0] rem_q, rem_d;
  logic [DIVW-1:0] dvs_q, dvs_d;
  logic [DIVW:0]   trial;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, quot_q[30]};
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = 5'd0;
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (run_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = DIVW'(trial - {1'b0, dvs_q});
        quot_d = {quot_q[29:0], 1'b1};
      end else begin
        rem_d  = trial[DIVW-1:0];
        quot_d = {quot_q[29:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd30) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

@@ rtl/lmro_index_mem.sv @@
// ---------------------------------------------------------------------------
// lmro_index_mem
// index value store, one write and one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module lmro_index_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [15:0]   wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic [15:0]        rdata_o
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/labeled_mixed_radix_offset.sv @@
// ---------------------------------------------------------------------------
// labeled_mixed_radix_offset
// dimension table with labeled forward offset lookup and reverse decompose
// ---------------------------------------------------------------------------
// channel  | dir | handshake        | contents
// s_axis   | in  | tvalid / tready  | load, coordinate pair or reverse query item
// m_axis   | out | tvalid / tready  | forward offset or reverse label/value result
// apb      | in  | psel / penable   | dims_in_use register, always ready
//
// loads and non-final pairs are stored without leaving the idle state;
// s_axis_tready is high only while the sequencer is idle
// forward: per dimension a setup step, a scan of the buffered pairs and, per
// index probed, a memory read, then a compare; a closing step loads the result
// into the output register
// reverse: per dimension with a nonzero count a setup step, a wait on the shared
// divider for its 31-bit quotient, then the emit with the index memory read; a
// dimension with a zero count is reported from its setup step
// a result waits in the output register while m_axis_tready is low; the
// sequencer holds until the register frees
// reset clears the dimension tables, pair fill and overflow; the index store
// and pair buffers hold no reset
// ---------------------------------------------------------------------------
`default_nettype none

module labeled_mixed_radix_offset #(
  parameter int unsigned MAX_DIMS    = 16,
  parameter int unsigned MAX_INDICES = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // stream in
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // slot[3:0] label[10:4] count[17:11] position[23:18] coord_value[39:24]
  // query_offset[70:40] zero[71]
  input  wire logic [71:0] s_axis_tdata,
  // opcode[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  // last_pair
  input  wire logic        s_axis_tlast,
  // stream out
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // offset[30:0] out_slot[34:31] out_label[41:35] out_value[57:42]
  // status[60:58] zero[63:61]
  output logic [63:0]      m_axis_tdata,
  // kind[0]
  output logic             m_axis_tuser,
  // last_result
  output logic             m_axis_tlast,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned FW    = $clog2(MAX_DIMS + 1);
  localparam int unsigned CW    = $clog2(MAX_INDICES + 1);
  localparam int unsigned ACCW  = 31 + CW;
  localparam int unsigned LIM   = (MAX_DIMS < 16) ? MAX_DIMS : 16;
  localparam int unsigned DEPTH = MAX_DIMS * MAX_INDICES;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // input fields
  logic [1:0]  in_op;
  logic [3:0]  in_slot;
  logic [6:0]  in_label;
  logic [6:0]  in_count;
  logic [5:0]  in_pos;
  logic [15:0] in_value;
  logic [30:0] in_qoff;
  logic        in_acc;

  assign in_slot  = s_axis_tdata[3:0];
  assign in_label = s_axis_tdata[10:4];
  assign in_count = s_axis_tdata[17:11];
  assign in_pos   = s_axis_tdata[23:18];
  assign in_value = s_axis_tdata[39:24];
  assign in_qoff  = s_axis_tdata[70:40];
  assign in_op    = s_axis_tuser;
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  // configuration
  logic [4:0] dims_q;
  logic [4:0] n_act;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == lmro_pkg::REG_DIMS) ? {27'd0, dims_q} : 32'd0;
  assign n_act  = (dims_q > 5'(LIM)) ? 5'(LIM) : dims_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= 5'd0;
    end else if (psel && penable && pwrite && paddr[2] == lmro_pkg::REG_DIMS) begin
      dims_q <= pwdata[4:0];
    end
  end

  // descriptor tables and pair buffer
  logic [6:0]    dim_lab_q [MAX_DIMS];
  logic [CW-1:0] dim_cnt_q [MAX_DIMS];
  logic [6:0]    pair_lab_q [MAX_DIMS];
  logic [15:0]   pair_val_q [MAX_DIMS];
  logic [FW-1:0] fill_q;
  logic          ovf_q;
  logic          fill_clr;

  logic slot_ok, pos_ok, fill_room;
  assign slot_ok   = 32'(in_slot) < MAX_DIMS;
  assign pos_ok    = 32'(in_pos) < MAX_INDICES;
  assign fill_room = 32'(fill_q) < MAX_DIMS;

  logic [CW-1:0] cnt_clamp;
  assign cnt_clamp = (32'(in_count) > MAX_INDICES) ? CW'(MAX_INDICES) : CW'(in_count);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        dim_lab_q[d] <= 7'd0;
        dim_cnt_q[d] <= '0;
      end
      fill_q <= '0;
      ovf_q  <= 1'b0;
    end else begin
      if (in_acc && in_op == lmro_pkg::OP_HEADER && slot_ok) begin
        dim_lab_q[DW'(in_slot)] <= in_label;
        dim_cnt_q[DW'(in_slot)] <= cnt_clamp;
      end
      if (in_acc && in_op == lmro_pkg::OP_PAIR) begin
        if (fill_room) begin
          fill_q <= fill_q + FW'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (fill_clr) begin
        fill_q <= '0;
        ovf_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_op == lmro_pkg::OP_PAIR && fill_room) begin
      pair_lab_q[fill_q[DW-1:0]] <= in_label;
      pair_val_q[fill_q[DW-1:0]] <= in_value;
    end
  end

  // sequencer state
  lmro_pkg::state_e state_q, state_d;
  logic [4:0]      i_q, i_d;
  logic [FW-1:0]   j_q, j_d;
  logic [CW-1:0]   k_q, k_d;
  logic [ACCW-1:0] acc_q, acc_d;
  logic [2:0]      st_q, st_d;
  logic [30:0]     disp_q, disp_d;

  logic [6:0]    cur_lab;
  logic [CW-1:0] cur_cnt;
  assign cur_lab = dim_lab_q[i_q[DW-1:0]];
  assign cur_cnt = dim_cnt_q[i_q[DW-1:0]];

  // shared divider
  logic          div_start, div_done;
  logic [30:0]   div_quot;
  logic [CW-1:0] div_rem;

  lmro_div #(.DIVW(CW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (disp_q),
    .divisor_i  (cur_cnt),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // index memory
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]   mem_rdata;
  logic [CW-1:0] rd_idx;

  assign mem_we    = in_acc && in_op == lmro_pkg::OP_VALUE && slot_ok && pos_ok;
  assign mem_waddr = AW'(32'(in_slot) * MAX_INDICES + 32'(in_pos));
  assign rd_idx    = (state_q == lmro_pkg::ST_R_DIVW) ? div_rem : k_q;
  assign mem_raddr = AW'(32'(i_q) * MAX_INDICES + 32'(rd_idx));

  lmro_index_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (in_value),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register
  logic        ovld_q;
  logic [63:0] odata_q;
  logic        okind_q, olast_q;
  logic        out_free, out_load;
  logic        r_kind, r_last;
  logic [30:0] r_off;
  logic [3:0]  r_slot;
  logic [6:0]  r_lab;
  logic [15:0] r_val;
  logic [2:0]  r_stat;

  assign out_free = !ovld_q || m_axis_tready;

  logic [ACCW-1:0] prod, sum;
  assign prod = acc_q[30:0] * cur_cnt;
  assign sum  = acc_q + ACCW'(k_q);

  assign s_axis_tready = (state_q == lmro_pkg::ST_IDLE);

  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    acc_d     = acc_q;
    st_d      = st_q;
    disp_d    = disp_q;
    div_start = 1'b0;
    mem_re    = 1'b0;
    fill_clr  = 1'b0;
    out_load  = 1'b0;
    r_kind    = lmro_pkg::KIND_FWD;
    r_off     = 31'd0;
    r_slot    = 4'd0;
    r_lab     = 7'd0;
    r_val     = 16'd0;
    r_stat    = lmro_pkg::STAT_OK;
    r_last    = 1'b0;
    case (state_q)
      lmro_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_op == lmro_pkg::OP_PAIR && s_axis_tlast) begin
            i_d     = 5'd0;
            acc_d   = '0;
            st_d    = lmro_pkg::STAT_OK;
            state_d = lmro_pkg::ST_F_DIM;
          end else if (in_op == lmro_pkg::OP_REV) begin
            disp_d = in_qoff;
            if (n_act == 5'd0) begin
              state_d = lmro_pkg::ST_R_NONE;
            end else begin
              i_d     = n_act - 5'd1;
              state_d = lmro_pkg::ST_R_DIM;
            end
          end
        end
      end
      lmro_pkg::ST_F_DIM: begin
        if (i_q >= n_act) begin
          state_d = lmro_pkg::ST_F_FIN;
        end else begin
          if (i_q != 5'd0) begin
            acc_d = prod;
          end
          j_d     = '0;
          state_d = lmro_pkg::ST_F_PAIR;
        end
      end
      lmro_pkg::ST_F_PAIR: begin
        // first buffered pair carrying this dimension's label
        if (j_q >= fill_q) begin
          st_d    = lmro_pkg::STAT_NO_LABEL;
          state_d = lmro_pkg::ST_F_FIN;
        end else if (pair_lab_q[j_q[DW-1:0]] == cur_lab) begin
          k_d     = '0;
          state_d = lmro_pkg::ST_F_VADDR;
        end else begin
          j_d = j_q + FW'(1);
        end
      end
      lmro_pkg::ST_F_VADDR: begin
        if (k_q >= cur_cnt) begin
          st_d    = lmro_pkg::STAT_NO_VALUE;
          state_d = lmro_pkg::ST_F_FIN;
        end else begin
          mem_re  = 1'b1;
          state_d = lmro_pkg::ST_F_VCMP;
        end
      end
      lmro_pkg::ST_F_VCMP: begin
        if (mem_rdata == pair_val_q[j_q[DW-1:0]]) begin
          acc_d = sum;
          if (sum > ACCW'(lmro_pkg::OFFSET_MAX)) begin
            st_d    = lmro_pkg::STAT_TOO_LARGE;
            state_d = lmro_pkg::ST_F_FIN;
          end else begin
            i_d     = i_q + 5'd1;
            state_d = lmro_pkg::ST_F_DIM;
          end
        end else begin
          k_d     = k_q + CW'(1);
          state_d = lmro_pkg::ST_F_VADDR;
        end
      end
      lmro_pkg::ST_F_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          r_kind   = lmro_pkg::KIND_FWD;
          r_last   = 1'b1;
          if (st_q != lmro_pkg::STAT_OK) begin
            r_stat = st_q;
          end else if (ovf_q) begin
            r_stat = lmro_pkg::STAT_ZERO_OVF;
          end else begin
            r_off = acc_q[30:0];
          end
          fill_clr = 1'b1;
          state_d  = lmro_pkg::ST_IDLE;
        end
      end
      lmro_pkg::ST_R_NONE: begin
        if (out_free) begin
          out_load = 1'b1;
          r_kind   = lmro_pkg::KIND_REV;
          r_last   = 1'b1;
          r_stat   = (disp_q != 31'd0) ? lmro_pkg::STAT_TOO_LARGE : lmro_pkg::STAT_OK;
          state_d  = lmro_pkg::ST_IDLE;
        end
      end
      lmro_pkg::ST_R_DIM: begin
        if (cur_cnt == '0) begin
          // zero count: report and pass the offset on undivided
          if (out_free) begin
            out_load = 1'b1;
            r_kind   = lmro_pkg::KIND_REV;
            r_slot   = i_q[3:0];
            r_lab    = cur_lab;
            r_stat   = lmro_pkg::STAT_ZERO_OVF;
            r_last   = (i_q == 5'd0);
            if (i_q == 5'd0) begin
              state_d = lmro_pkg::ST_IDLE;
            end else begin
              i_d = i_q - 5'd1;
            end
          end
        end else begin
          div_start = 1'b1;
          state_d   = lmro_pkg::ST_R_DIVW;
        end
      end
      lmro_pkg::ST_R_DIVW: begin
        if (div_done) begin
          disp_d  = div_quot;
          mem_re  = 1'b1;
          state_d = lmro_pkg::ST_R_EMIT;
        end
      end
      lmro_pkg::ST_R_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          r_kind   = lmro_pkg::KIND_REV;
          r_slot   = i_q[3:0];
          r_lab    = cur_lab;
          r_val    = mem_rdata;
          r_last   = (i_q == 5'd0);
          // leftover after the first dimension
          if (i_q == 5'd0 && disp_q != 31'd0) begin
            r_stat = lmro_pkg::STAT_TOO_LARGE;
          end
          if (i_q == 5'd0) begin
            state_d = lmro_pkg::ST_IDLE;
          end else begin
            i_d     = i_q - 5'd1;
            state_d = lmro_pkg::ST_R_DIM;
          end
        end
      end
      default: begin
        state_d = lmro_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lmro_pkg::ST_IDLE;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        ovld_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    k_q    <= k_d;
    acc_q  <= acc_d;
    st_q   <= st_d;
    disp_q <= disp_d;
    if (out_load) begin
      odata_q <= {3'd0, r_stat, r_val, r_lab, r_slot, r_off};
      okind_q <= r_kind;
      olast_q <= r_last;
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = olast_q;

endmodule

`default_nettype wire

@@ rtl/lmro_checker.sv @@
// ---------------------------------------------------------------------------
// lmro_checker
// port-level checks on the result stream, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "labeled_mixed_radix_offset_assert.svh"

module lmro_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata,
  input wire logic        m_axis_tuser,
  input wire logic        m_axis_tlast
);

  `LMRO_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `LMRO_ASSERT_IMP(a_fwd_last, m_axis_tvalid && m_axis_tuser == lmro_pkg::KIND_FWD, m_axis_tlast, "forward result without last")
  `LMRO_ASSERT_IMP(a_err_zero, m_axis_tvalid && m_axis_tdata[60:58] != lmro_pkg::STAT_OK && m_axis_tuser == lmro_pkg::KIND_FWD, m_axis_tdata[30:0] == 31'd0, "forward error with offset")
  `LMRO_ASSERT_IMP(a_rev_zero, m_axis_tvalid && m_axis_tuser == lmro_pkg::KIND_REV, m_axis_tdata[30:0] == 31'd0, "reverse result with offset")

endmodule

bind labeled_mixed_radix_offset lmro_checker u_lmro_checker (.*);

`default_nettype wire
